@@ hdl/sls_attenuation_memory_update_top_macros.svh @@
// assertion helpers used by the checker file sls_amu_checker.sv
`ifndef SLS_ATTENUATION_MEMORY_UPDATE_TOP_MACROS_SVH
`define SLS_ATTENUATION_MEMORY_UPDATE_TOP_MACROS_SVH

// consequent checked in the same cycle
`define SLS_AMU_ASSERT_NOW(lbl, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error("sls_amu: same-cycle check failed");

// consequent checked in the next cycle
`define SLS_AMU_ASSERT_NEXT(lbl, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error("sls_amu: next-cycle check failed");

`endif

@@ hdl/sls_amu_pkg.sv @@
package sls_amu_pkg;

    localparam int MAX_MECH      = 5;
    localparam int MODES         = 64;
    localparam int POINTS        = 4;
    localparam int NCOMP         = 6;
    localparam int MODE_W        = 6;
    localparam int PT_W          = 2;
    localparam int ROWS_PER_MECH = MODES * POINTS;
    localparam int MEM_ROWS      = MAX_MECH * ROWS_PER_MECH;
    localparam int MEM_AW        = $clog2(MEM_ROWS);
    localparam int SR_AW         = (ROWS_PER_MECH > 1) ? $clog2(ROWS_PER_MECH) : 1;
    localparam int MECH_W        = $clog2(MAX_MECH + 1);
    localparam int MIDX_W        = (MAX_MECH > 1) ? $clog2(MAX_MECH) : 1;
    localparam int ROW_W         = 64 * NCOMP;
    localparam int LANES         = 2 * NCOMP;
    localparam int ACC_W         = 32 + $clog2(MAX_MECH + 1);
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_W         = 60;

    localparam int THREE         = 3;
    localparam int TWO           = 2;
    localparam int THIRD_Q30     = 357913941;

    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_USE_BULK = 3'd1;
    localparam int                   REG_COEF0    = 2;

    typedef enum logic [1:0] {
        REQ_UPDATE = 2'd0,
        REQ_APPLY  = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [MODE_W-1:0]  mode_index;
        logic [PT_W-1:0]    point_index;
        logic [63:0]        comp_0;
        logic [63:0]        comp_1;
        logic [63:0]        comp_2;
        logic [63:0]        comp_3;
        logic [63:0]        comp_4;
        logic [63:0]        comp_5;
        logic signed [31:0] shear_change;
        logic signed [31:0] bulk_change;
    } cmd_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode_out;
        logic [PT_W-1:0]   point_out;
        logic [63:0]       stress_0;
        logic [63:0]       stress_1;
        logic [63:0]       stress_2;
        logic [63:0]       stress_3;
        logic [63:0]       stress_4;
        logic [63:0]       stress_5;
    } result_t;

    typedef struct packed {
        logic signed [19:0] a;
        logic signed [19:0] b;
        logic signed [19:0] g;
    } coef_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sh0000_0000_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        if (v < -64'sh0000_0000_8000_0000)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // floor(v / 2^s + 1/2)
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input int s);
        logic signed [63:0] t;
        t = v + (64'sd1 <<< (s - 1));
        return t >>> s;
    endfunction

    function automatic logic [MEM_AW-1:0] mem_row(input logic [MIDX_W-1:0] m,
                                                  input logic [MODE_W-1:0] mode,
                                                  input logic [PT_W-1:0] pt);
        return MEM_AW'(int'(m) * ROWS_PER_MECH + int'(mode) * POINTS + int'(pt));
    endfunction

    function automatic logic [SR_AW-1:0] sr_row(input logic [MODE_W-1:0] mode,
                                                input logic [PT_W-1:0] pt);
        return SR_AW'(int'(mode) * POINTS + int'(pt));
    endfunction

endpackage

@@ hdl/sls_amu_ram.sv @@
module sls_amu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hdl/sls_amu_relax.sv @@
module sls_amu_relax import sls_amu_pkg::*; (
    input  logic             clk,
    input  cmd_t             item,
    input  logic             use_bulk,
    output logic [ROW_W-1:0] sr_row
);

    logic [63:0]        comp [NCOMP];
    logic signed [31:0] sr_part [2][NCOMP];

    assign comp[0] = item.comp_0;
    assign comp[1] = item.comp_1;
    assign comp[2] = item.comp_2;
    assign comp[3] = item.comp_3;
    assign comp[4] = item.comp_4;
    assign comp[5] = item.comp_5;

    // part 0 is the real half, part 1 the imaginary half
    for (genvar p = 0; p < 2; p++)
    begin : g_part
        localparam int LO = (p == 0) ? 32 : 0;

        logic signed [31:0] e [NCOMP];
        logic signed [31:0] e3_next;
        logic signed [31:0] e3_reg;
        logic signed [63:0] pd_next [NCOMP];
        logic signed [63:0] pd_reg [NCOMP];
        logic signed [63:0] pk_next;
        logic signed [63:0] pk_reg;
        logic signed [31:0] sr_next [NCOMP];
        logic signed [31:0] sr_reg [NCOMP];

        for (genvar c = 0; c < NCOMP; c++)
        begin : g_comp
            assign e[c]          = comp[c][LO +: 32];
            assign sr_part[p][c] = sr_reg[c];
        end

        // mean normal strain, third held in Q0.30
        always_comb
        begin
            logic signed [63:0] tr;
            tr      = 64'(e[0]) + 64'(e[1]) + 64'(e[2]);
            e3_next = sat32(rnd_shift(tr * THIRD_Q30, 30));
        end

        always_comb
        begin
            logic signed [31:0] d;
            for (int c = 0; c < NCOMP; c++)
            begin
                if (c < 3)
                begin
                    d          = sat32(64'(e[c]) - 64'(e3_reg));
                    pd_next[c] = 64'(item.shear_change) * 64'(d);
                end
                else
                begin
                    d          = e[c];
                    pd_next[c] = 64'(item.shear_change) * 64'(e[c]);
                end
            end
            pk_next = 64'(item.bulk_change) * 64'(e3_reg);
        end

        always_comb
        begin
            logic signed [31:0] s3;
            logic signed [31:0] dev;
            s3 = sat32(THREE * rnd_shift(pk_reg, 24));
            for (int c = 0; c < NCOMP; c++)
            begin
                if (c < 3)
                begin
                    dev        = sat32(TWO * rnd_shift(pd_reg[c], 24));
                    sr_next[c] = use_bulk ? sat32(64'(s3) + 64'(dev)) : dev;
                end
                else
                begin
                    dev        = 32'sd0;
                    sr_next[c] = sat32(rnd_shift(pd_reg[c], 24));
                end
            end
            // shear only: normal part kept trace-free
            if (!use_bulk)
            begin
                sr_next[2] = sat32(-(64'(sr_next[0]) + 64'(sr_next[1])));
            end
        end

        always_ff @(posedge clk)
        begin
            e3_reg <= e3_next;
            pd_reg <= pd_next;
            pk_reg <= pk_next;
            sr_reg <= sr_next;
        end
    end

    for (genvar c = 0; c < NCOMP; c++)
    begin : g_pack
        assign sr_row[c*64 +: 64] = {sr_part[0][c], sr_part[1][c]};
    end

endmodule

@@ hdl/sls_amu_mech.sv @@
module sls_amu_mech import sls_amu_pkg::*; (
    input  logic             clk,
    input  coef_t            coef,
    input  logic [ROW_W-1:0] mem_row_in,
    input  logic [ROW_W-1:0] old_row,
    input  logic [ROW_W-1:0] new_row,
    output logic [ROW_W-1:0] upd_row
);

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        logic signed [31:0] mv;
        logic signed [31:0] ov;
        logic signed [31:0] nv;
        logic signed [63:0] pa_reg;
        logic signed [63:0] pb_reg;
        logic signed [63:0] pg_reg;
        logic signed [31:0] decay;

        assign mv = mem_row_in[l*32 +: 32];
        assign ov = old_row[l*32 +: 32];
        assign nv = new_row[l*32 +: 32];

        always_ff @(posedge clk)
        begin
            pa_reg <= 64'(coef.a) * 64'(mv);
            pb_reg <= 64'(coef.b) * 64'(ov);
            pg_reg <= 64'(coef.g) * 64'(nv);
        end

        // decay first, then add the fresh relaxed stress
        assign decay = sat32(rnd_shift(pa_reg + pb_reg, 18));
        assign upd_row[l*32 +: 32] = sat32(64'(decay) + rnd_shift(pg_reg, 18));
    end

endmodule

@@ hdl/sls_attenuation_memory_update_top.sv @@
// channel   | signals                         | handshake
// request   | start, busy, cmd (cmd_t)        | taken when start && !busy
// result    | result_valid, result (result_t) | one-cycle strobe, no back-pressure
// config    | cfg_we, cfg_index, cfg_data     | written when cfg_we is high
//
// update: ST_RELAX forms the relaxed stress, then ST_UPD updates one memory row
//   per cycle, one per mechanism in use
// apply: the result strobes as busy drops
// clear and reset: a sweep of the MEM_ROWS (1280) memory-variable rows and the
//   relaxed-stress rows, one row a cycle, during which no request is taken
// the receiver cannot stall results
module sls_attenuation_memory_update_top import sls_amu_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  cmd_t                 cmd,
    output logic                 result_valid,
    output result_t              result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    typedef enum logic [4:0] {
        ST_SWEEP = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_RELAX = 5'b00100,
        ST_UPD   = 5'b01000,
        ST_APPLY = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    cmd_t   cmd_reg;

    logic [MEM_AW-1:0] sweep_reg, sweep_next;
    logic [1:0]        step_reg, step_next;
    logic [MECH_W-1:0] mech_reg, mech_next;
    logic              v1_reg, v2_reg;
    logic [MIDX_W-1:0] m1_reg, m2_reg;

    logic [2:0]        active_reg;
    logic              use_bulk_reg;
    coef_t             coef_reg [MAX_MECH];

    logic signed [ACC_W-1:0] acc_reg [LANES];
    result_t           result_reg;
    logic              result_valid_reg, result_valid_next;

    logic              accept;
    logic [MECH_W-1:0] mech_cnt;
    logic              issue;
    logic              apply_done;

    logic              mem_we, mem_re, sr_we, sr_re;
    logic [MEM_AW-1:0] mem_waddr, mem_raddr;
    logic [SR_AW-1:0]  sr_waddr;
    logic [ROW_W-1:0]  mem_wdata, mem_rdata, sr_wdata, sr_rdata;
    logic [ROW_W-1:0]  new_row, upd_row, comp_row, stress_row;

    assign accept   = start && (state_reg == ST_IDLE);
    assign busy     = (state_reg != ST_IDLE);
    assign mech_cnt = (int'(active_reg) > MAX_MECH) ? MECH_W'(MAX_MECH)
                                                    : MECH_W'(active_reg);
    assign issue    = ((state_reg == ST_UPD) || (state_reg == ST_APPLY))
                      && (mech_reg < mech_cnt);
    assign apply_done = (state_reg == ST_APPLY) && !issue && !v1_reg;

    assign comp_row = {cmd_reg.comp_5, cmd_reg.comp_4, cmd_reg.comp_3,
                       cmd_reg.comp_2, cmd_reg.comp_1, cmd_reg.comp_0};

    always_comb
    begin
        state_next        = state_reg;
        sweep_next        = sweep_reg;
        step_next         = step_reg;
        mech_next         = issue ? mech_reg + MECH_W'(1) : mech_reg;
        result_valid_next = 1'b0;
        unique case (state_reg)
            ST_SWEEP:
            begin
                sweep_next = sweep_reg + MEM_AW'(1);
                if (sweep_reg == MEM_AW'(MEM_ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                mech_next = '0;
                step_next = '0;
                sweep_next = '0;
                if (start)
                begin
                    unique case (cmd.req_type)
                        REQ_UPDATE: state_next = ST_RELAX;
                        REQ_APPLY:  state_next = ST_APPLY;
                        REQ_CLEAR:  state_next = ST_SWEEP;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_RELAX:
            begin
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd2)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                if (!issue && !v1_reg && !v2_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_APPLY:
            begin
                if (apply_done)
                begin
                    state_next        = ST_IDLE;
                    result_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_SWEEP;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_SWEEP;
            sweep_reg        <= '0;
            step_reg         <= '0;
            mech_reg         <= '0;
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            sweep_reg        <= sweep_next;
            step_reg         <= step_next;
            mech_reg         <= mech_next;
            v1_reg           <= issue;
            v2_reg           <= v1_reg && (state_reg == ST_UPD);
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 3'd1;
            use_bulk_reg <= 1'b1;
            for (int k = 0; k < MAX_MECH; k++)
            begin
                coef_reg[k] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_ACTIVE)
            begin
                active_reg <= cfg_data[2:0];
            end
            if (cfg_index == REG_USE_BULK)
            begin
                use_bulk_reg <= cfg_data[0];
            end
            for (int k = 0; k < MAX_MECH; k++)
            begin
                if (cfg_index == CFG_IDX_W'(REG_COEF0 + k))
                begin
                    coef_reg[k] <= coef_t'(cfg_data);
                end
            end
        end
    end

    // request payload and mechanism pipeline tags
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd;
        end
        m1_reg <= mech_reg[MIDX_W-1:0];
        m2_reg <= m1_reg;
    end

    // apply sums the active memory variables lane by lane
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < LANES; l++)
        begin
            if (accept)
            begin
                acc_reg[l] <= '0;
            end
            else if (v1_reg && (state_reg == ST_APPLY))
            begin
                acc_reg[l] <= acc_reg[l] + ACC_W'(signed'(mem_rdata[l*32 +: 32]));
            end
        end
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_out
        assign stress_row[l*32 +: 32] =
            sat32(64'(signed'(comp_row[l*32 +: 32])) - 64'(acc_reg[l]));
    end

    always_ff @(posedge clk)
    begin
        if (apply_done)
        begin
            result_reg.mode_out  <= cmd_reg.mode_index;
            result_reg.point_out <= cmd_reg.point_index;
            result_reg.stress_0  <= stress_row[0*64 +: 64];
            result_reg.stress_1  <= stress_row[1*64 +: 64];
            result_reg.stress_2  <= stress_row[2*64 +: 64];
            result_reg.stress_3  <= stress_row[3*64 +: 64];
            result_reg.stress_4  <= stress_row[4*64 +: 64];
            result_reg.stress_5  <= stress_row[5*64 +: 64];
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // memory-variable ram: sweep clears, update writes back after two stages
    assign mem_re    = issue;
    assign mem_raddr = mem_row(mech_reg[MIDX_W-1:0], cmd_reg.mode_index,
                               cmd_reg.point_index);
    assign mem_we    = (state_reg == ST_SWEEP) || (v2_reg && (state_reg == ST_UPD));
    assign mem_waddr = (state_reg == ST_SWEEP) ? sweep_reg
                       : mem_row(m2_reg, cmd_reg.mode_index, cmd_reg.point_index);
    assign mem_wdata = (state_reg == ST_SWEEP) ? '0 : upd_row;

    // relaxed-stress ram: old row read when an update is accepted, new row written during update, cleared by the sweep
    assign sr_re    = accept && (cmd.req_type == REQ_UPDATE);
    assign sr_we    = ((state_reg == ST_SWEEP)
                       && ({1'b0, sweep_reg} < (MEM_AW + 1)'(ROWS_PER_MECH)))
                      || (state_reg == ST_UPD);
    assign sr_waddr = (state_reg == ST_SWEEP) ? sweep_reg[SR_AW-1:0]
                      : sr_row(cmd_reg.mode_index, cmd_reg.point_index);
    assign sr_wdata = (state_reg == ST_SWEEP) ? '0 : new_row;

    sls_amu_ram #(
        .WIDTH(ROW_W),
        .DEPTH(MEM_ROWS)
    ) u_mem_ram (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re   (mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    sls_amu_ram #(
        .WIDTH(ROW_W),
        .DEPTH(ROWS_PER_MECH)
    ) u_sr_ram (
        .clk  (clk),
        .we   (sr_we),
        .waddr(sr_waddr),
        .wdata(sr_wdata),
        .re   (sr_re),
        .raddr(sr_row(cmd.mode_index, cmd.point_index)),
        .rdata(sr_rdata)
    );

    sls_amu_relax u_relax (
        .clk     (clk),
        .item    (cmd_reg),
        .use_bulk(use_bulk_reg),
        .sr_row  (new_row)
    );

    sls_amu_mech u_mech (
        .clk       (clk),
        .coef      (coef_reg[m1_reg]),
        .mem_row_in(mem_rdata),
        .old_row   (sr_rdata),
        .new_row   (new_row),
        .upd_row   (upd_row)
    );

endmodule

@@ hdl/sls_amu_checker.sv @@
`include "sls_attenuation_memory_update_top_macros.svh"

module sls_amu_checker import sls_amu_pkg::*; (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input cmd_t cmd,
    input logic result_valid
);

    `SLS_AMU_ASSERT_NEXT(a_strobe_single, result_valid, !result_valid)
    `SLS_AMU_ASSERT_NOW(a_result_when_idle, result_valid, !busy)
    `SLS_AMU_ASSERT_NEXT(a_busy_after_request, start && !busy && cmd.req_type != REQ_NONE, busy)
    `SLS_AMU_ASSERT_NEXT(a_apply_only, start && !busy && cmd.req_type != REQ_APPLY, !result_valid)

endmodule

bind sls_attenuation_memory_update_top sls_amu_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .result_valid(result_valid)
);

@@ tb/sls_attenuation_memory_update_top_tb.sv @@
`timescale 1ns / 1ps

module sls_attenuation_memory_update_top_tb;
    import sls_amu_pkg::*;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int N_MEM = MAX_MECH * MODES * POINTS * NCOMP;
    localparam int N_SR  = MODES * POINTS * NCOMP;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    cmd_t                 cmd;
    logic                 result_valid;
    result_t              result;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    sls_attenuation_memory_update_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // predicted block state
    logic [63:0] mv_model [N_MEM];
    logic [63:0] sr_model [N_SR];
    logic [2:0]  mech_active_model;
    logic        bulk_model;
    logic [59:0] coef_model [MAX_MECH];

    result_t stress_expected [$];
    int      n_requests;
    int      n_results;
    int      n_errors;
    int      idle_cycles;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // floor(v / 2^s + 1/2)
    function automatic longint round_shift(longint v, int s);
        longint t;
        t = v + (longint'(1) <<< (s - 1));
        return t >>> s;
    endfunction

    function automatic longint half(logic [63:0] w, int p);
        logic signed [31:0] h;
        h = p ? w[31:0] : w[63:32];
        return longint'(h);
    endfunction

    function automatic logic [63:0] join_parts(longint re, longint im);
        return {re[31:0], im[31:0]};
    endfunction

    function automatic longint coef_field(logic [59:0] w, int sh);
        logic signed [19:0] f;
        f = 20'(w >> sh);
        return longint'(f);
    endfunction

    function automatic int mv_idx(int m, int mode, int pt, int c);
        return ((m * MODES + mode) * POINTS + pt) * NCOMP + c;
    endfunction

    function automatic int sr_idx(int mode, int pt, int c);
        return (mode * POINTS + pt) * NCOMP + c;
    endfunction

    function automatic logic [63:0] cmd_comp(cmd_t c, int i);
        logic [$bits(cmd_t)-1:0] flat;
        flat = c;
        return flat[$bits(cmd_t)-11-64*i -: 64];
    endfunction

    function automatic logic [63:0] res_stress(result_t r, int i);
        logic [$bits(result_t)-1:0] flat;
        flat = r;
        return flat[$bits(result_t)-9-64*i -: 64];
    endfunction

    function automatic int mech_in_use();
        return (mech_active_model > MAX_MECH) ? MAX_MECH : int'(mech_active_model);
    endfunction

    task automatic clear_model();
        foreach (mv_model[i])
            mv_model[i] = '0;
        foreach (sr_model[i])
            sr_model[i] = '0;
    endtask

    task automatic update_model(cmd_t c);
        int      nm;
        int      mode;
        int      pt;
        longint  dmu;
        longint  dk;
        longint  a;
        longint  b;
        longint  g;
        longint  r [2];
        longint  e [NCOMP];
        longint  e3;
        longint  s3;
        longint  dev;
        longint  srv [2][NCOMP];
        nm   = mech_in_use();
        mode = c.mode_index;
        pt   = c.point_index;
        dmu  = longint'(c.shear_change);
        dk   = longint'(c.bulk_change);
        for (int m = 0; m < nm; m++)
        begin
            a = coef_field(coef_model[m], 40);
            b = coef_field(coef_model[m], 20);
            for (int k = 0; k < NCOMP; k++)
            begin
                for (int p = 0; p < 2; p++)
                    r[p] = clamp32(round_shift(a * half(mv_model[mv_idx(m, mode, pt, k)], p)
                                   + b * half(sr_model[sr_idx(mode, pt, k)], p), 18));
                mv_model[mv_idx(m, mode, pt, k)] = join_parts(r[0], r[1]);
            end
        end
        for (int p = 0; p < 2; p++)
        begin
            for (int k = 0; k < NCOMP; k++)
                e[k] = half(cmd_comp(c, k), p);
            e3 = clamp32(round_shift((e[0] + e[1] + e[2]) * THIRD_Q30, 30));
            s3 = 0;
            if (bulk_model)
                s3 = clamp32(THREE * round_shift(dk * e3, 24));
            for (int k = 0; k < 3; k++)
            begin
                dev = clamp32(TWO * round_shift(dmu * clamp32(e[k] - e3), 24));
                srv[p][k] = bulk_model ? clamp32(s3 + dev) : dev;
            end
            // trace-free normal part without bulk
            if (!bulk_model)
                srv[p][2] = clamp32(-(srv[p][0] + srv[p][1]));
            for (int k = 3; k < NCOMP; k++)
                srv[p][k] = clamp32(round_shift(dmu * e[k], 24));
        end
        for (int k = 0; k < NCOMP; k++)
            sr_model[sr_idx(mode, pt, k)] = join_parts(srv[0][k], srv[1][k]);
        for (int m = 0; m < nm; m++)
        begin
            g = coef_field(coef_model[m], 0);
            for (int k = 0; k < NCOMP; k++)
            begin
                for (int p = 0; p < 2; p++)
                    r[p] = clamp32(half(mv_model[mv_idx(m, mode, pt, k)], p)
                                   + round_shift(g * half(sr_model[sr_idx(mode, pt, k)], p), 18));
                mv_model[mv_idx(m, mode, pt, k)] = join_parts(r[0], r[1]);
            end
        end
    endtask

    function automatic result_t corrected_stress(cmd_t c);
        result_t                  res;
        logic [$bits(result_t)-1:0] flat;
        longint                   sum;
        longint                   r [2];
        int                       nm;
        nm = mech_in_use();
        flat = '0;
        flat[$bits(result_t)-1 -: 6] = c.mode_index;
        flat[$bits(result_t)-7 -: 2] = c.point_index;
        for (int k = 0; k < NCOMP; k++)
        begin
            for (int p = 0; p < 2; p++)
            begin
                sum = 0;
                for (int m = 0; m < nm; m++)
                    sum += half(mv_model[mv_idx(m, c.mode_index, c.point_index, k)], p);
                r[p] = clamp32(half(cmd_comp(c, k), p) - sum);
            end
            flat[$bits(result_t)-9-64*k -: 64] = join_parts(r[0], r[1]);
        end
        res = flat;
        return res;
    endfunction

    // request acceptance and prediction
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
        begin
            n_requests++;
            case (req_t'(cmd.req_type))
                REQ_UPDATE: update_model(cmd);
                REQ_APPLY:  stress_expected.push_back(corrected_stress(cmd));
                REQ_CLEAR:  clear_model();
                default:    ;
            endcase
        end
    end

    // result check
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && result_valid)
        begin
            n_results++;
            if (stress_expected.size() == 0)
            begin
                n_errors++;
                $display("%0t unexpected result: expected none, actual %h", $time, result);
            end
            else
            begin
                want = stress_expected.pop_front();
                if (want.mode_out !== result.mode_out)
                begin
                    n_errors++;
                    $display("%0t mode_out: expected %h, actual %h",
                             $time, want.mode_out, result.mode_out);
                end
                if (want.point_out !== result.point_out)
                begin
                    n_errors++;
                    $display("%0t point_out: expected %h, actual %h",
                             $time, want.point_out, result.point_out);
                end
                for (int k = 0; k < NCOMP; k++)
                    if (res_stress(want, k) !== res_stress(result, k))
                    begin
                        n_errors++;
                        $display("%0t stress_%0d: expected %h, actual %h",
                                 $time, k, res_stress(want, k), res_stress(result, k));
                    end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((rst_n && start && !busy) || result_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_request(cmd_t c);
        int gap;
        gap = $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        // start stays high; the next call or an idle wait decides
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (stress_expected.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ACTIVE:   mech_active_model = data[2:0];
            REG_USE_BULK: bulk_model = data[0];
            default:
                if (int'(idx) >= REG_COEF0 && int'(idx) < REG_COEF0 + MAX_MECH)
                    coef_model[int'(idx) - REG_COEF0] = data;
        endcase
        @(posedge clk);
    endtask

    function automatic logic [31:0] rand_half();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return $urandom_range(0, 32'h00FF_FFFF);
            4: return -$urandom_range(0, 32'h00FF_FFFF);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [19:0] rand_coef(bit mild);
        if (mild)
            return 20'($urandom_range(0, 20'h7FFFF)) >>> $urandom_range(0, 3);
        return 20'($urandom);
    endfunction

    function automatic cmd_t make_cmd(req_t rt, int mode, int pt);
        cmd_t c;
        logic [$bits(cmd_t)-1:0] flat;
        flat = '0;
        flat[$bits(cmd_t)-1 -: 2] = rt;
        flat[$bits(cmd_t)-3 -: 6] = 6'(mode);
        flat[$bits(cmd_t)-9 -: 2] = 2'(pt);
        for (int k = 0; k < NCOMP; k++)
            flat[$bits(cmd_t)-11-64*k -: 64] = {rand_half(), rand_half()};
        c = flat;
        c.shear_change = rand_half();
        c.bulk_change  = rand_half();
        return c;
    endfunction

    task automatic load_coefs(bit mild);
        for (int m = 0; m < MAX_MECH; m++)
            write_reg(CFG_IDX_W'(REG_COEF0 + m), {rand_coef(mild), rand_coef(mild), rand_coef(mild)});
    endtask

    task automatic test_defaults();
        // coefficients at zero, one mechanism, bulk on
        send_request(make_cmd(REQ_UPDATE, 0, 0));
        send_request(make_cmd(REQ_APPLY, 0, 0));
        send_request(make_cmd(REQ_NONE, 1, 1));
        send_request(make_cmd(REQ_APPLY, 63, 3));
        wait_idle();
    endtask

    task automatic test_extremes();
        cmd_t c;
        write_reg(REG_ACTIVE, 60'd5);
        for (int m = 0; m < MAX_MECH; m++)
            write_reg(CFG_IDX_W'(REG_COEF0 + m), {20'h7FFFF, 20'h7FFFF, 20'h7FFFF});
        c = make_cmd(REQ_UPDATE, 63, 3);
        for (int k = 0; k < NCOMP; k++)
            c[$bits(cmd_t)-11-64*k -: 64] = 64'h7FFF_FFFF_8000_0000;
        c.shear_change = 32'h7FFF_FFFF;
        c.bulk_change  = 32'h8000_0000;
        send_request(c);
        send_request(c);
        c.req_type = REQ_APPLY;
        send_request(c);
        wait_idle();
        write_reg(REG_USE_BULK, 60'd0);
        for (int m = 0; m < MAX_MECH; m++)
            write_reg(CFG_IDX_W'(REG_COEF0 + m), {20'h80000, 20'h80000, 20'h80000});
        send_request(make_cmd(REQ_UPDATE, 63, 3));
        send_request(make_cmd(REQ_APPLY, 63, 3));
        send_request(make_cmd(REQ_CLEAR, 0, 0));
        send_request(make_cmd(REQ_APPLY, 63, 3));
        wait_idle();
    endtask

    task automatic test_mech_counts();
        int counts [4] = '{0, 7, 6, 2};
        load_coefs(1'b1);
        write_reg(REG_USE_BULK, 60'd1);
        foreach (counts[i])
        begin
            // above five acts as five; inactive mechanisms keep their words
            write_reg(REG_ACTIVE, CFG_W'(counts[i]));
            send_request(make_cmd(REQ_UPDATE, 5, 2));
            send_request(make_cmd(REQ_APPLY, 5, 2));
            wait_idle();
        end
        write_reg(REG_ACTIVE, 60'd5);
        send_request(make_cmd(REQ_APPLY, 5, 2));
        wait_idle();
    endtask

    task automatic test_random();
        int     pick;
        int     mode;
        req_t   rt;
        for (int phase = 0; phase < 5; phase++)
        begin
            write_reg(REG_ACTIVE, CFG_W'($urandom_range(0, 7)));
            write_reg(REG_USE_BULK, CFG_W'($urandom_range(0, 1)));
            load_coefs(phase != 2);
            for (int n = 0; n < 100; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 47)
                    rt = REQ_UPDATE;
                else if (pick < 95)
                    rt = REQ_APPLY;
                else if (pick < 98)
                    rt = REQ_NONE;
                else
                    rt = REQ_CLEAR;
                mode = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, 63);
                send_request(make_cmd(rt, mode, $urandom_range(0, 3)));
            end
            // hold off until every result is back
            wait_idle();
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        cmd         = '0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        n_requests  = 0;
        n_results   = 0;
        n_errors    = 0;
        idle_cycles = 0;
        mech_active_model = 3'd1;
        bulk_model = 1'b1;
        foreach (coef_model[i])
            coef_model[i] = '0;
        clear_model();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        wait_idle();

        test_defaults();
        test_extremes();
        test_mech_counts();
        test_random();

        wait_idle();
        repeat (20) @(posedge clk);
        $display("covered %0d requests (update, apply, clear, unused code) and %0d results",
                 n_requests, n_results);
        $display("mechanism counts 0 to 7, bulk on and off, coefficient extremes");
        if (n_errors == 0 && stress_expected.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
